// ----- design/crc8sfc_pkg.sv -----
`default_nettype none

package crc8sfc_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 9;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [ByteW-1:0]  CrcPoly       = 8'h8C;
  localparam logic [ByteW-1:0]  CrcInit       = 8'hFF;
  localparam logic [ByteW-1:0]  HeaderReset   = 8'h7A;
  localparam logic [ByteW-1:0]  FooterReset   = 8'h0A;
  localparam logic [CountW-1:0] CountMax      = 9'd511;
  localparam logic [CountW-1:0] FrameOverhead = 9'd5;

  localparam logic [CountW-1:0] PosFirst   = 9'd0;
  localparam logic [CountW-1:0] PosCommand = 9'd1;
  localparam logic [CountW-1:0] PosLength  = 9'd2;

  localparam logic [CfgIdxW-1:0] CfgHeader = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFooter = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic             frame_ok;
    logic [ByteW-1:0] command;
    logic [ByteW-1:0] payload_length;
  } out_item_t;

  // Reflected CRC8, one byte at a time: eight shift-and-reduce steps.
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] data);
    logic [ByteW-1:0] v;
    v = crc ^ data;
    for (int k = 0; k < ByteW; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CrcPoly;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- design/crc8sfc_frame.sv -----
`default_nettype none

module crc8sfc_frame (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,
  input  wire crc8sfc_pkg::in_item_t   item_i,
  input  wire logic [7:0]              header_i,
  input  wire logic [7:0]              footer_i,
  output crc8sfc_pkg::out_item_t       result_o
);
  import crc8sfc_pkg::*;

  logic [ByteW-1:0]  crc_q, crc_d;
  logic [CountW-1:0] count_q, count_d;
  logic [ByteW-1:0]  first_q, first_d;
  logic [ByteW-1:0]  cmd_q, cmd_d;
  logic [ByteW-1:0]  len_byte_q, len_byte_d;
  logic [ByteW-1:0]  older_q, older_d;
  logic [ByteW-1:0]  newer_q, newer_d;

  logic [ByteW-1:0]  crc_now;
  logic [ByteW-1:0]  first_now, cmd_now, len_byte_now;
  logic [CountW-1:0] len;
  logic              len_ok;

  always_comb begin
    // The byte two places back leaves the delay line and enters the CRC.
    crc_now      = (count_q >= PosLength) ? crc8_update(crc_q, older_q) : crc_q;
    first_now    = (count_q == PosFirst)   ? item_i.rx_byte : first_q;
    cmd_now      = (count_q == PosCommand) ? item_i.rx_byte : cmd_q;
    len_byte_now = (count_q == PosLength)  ? item_i.rx_byte : len_byte_q;
    len          = (count_q != CountMax) ? count_q + CountW'(1) : CountMax;
    len_ok       = (len >= FrameOverhead)
                   && ({1'b0, len_byte_now} == (len - FrameOverhead));

    // On the last byte the newest delayed byte is the CRC and the input is the footer.
    result_o.frame_ok       = len_ok && (first_now == header_i)
                              && (item_i.rx_byte == footer_i) && (crc_now == newer_q);
    result_o.command        = (len >= PosLength) ? cmd_now : '0;
    result_o.payload_length = (len >= 9'd3) ? len_byte_now : '0;

    if (item_i.end_of_frame) begin
      crc_d      = CrcInit;
      count_d    = '0;
      first_d    = '0;
      cmd_d      = '0;
      len_byte_d = '0;
      older_d    = '0;
      newer_d    = '0;
    end else begin
      crc_d      = crc_now;
      count_d    = len;
      first_d    = first_now;
      cmd_d      = cmd_now;
      len_byte_d = len_byte_now;
      older_d    = newer_q;
      newer_d    = item_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CrcInit;
      count_q    <= '0;
      first_q    <= '0;
      cmd_q      <= '0;
      len_byte_q <= '0;
      older_q    <= '0;
      newer_q    <= '0;
    end else if (step_i) begin
      crc_q      <= crc_d;
      count_q    <= count_d;
      first_q    <= first_d;
      cmd_q      <= cmd_d;
      len_byte_q <= len_byte_d;
      older_q    <= older_d;
      newer_q    <= newer_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/crc8_serial_frame_checker.sv -----
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o   in_item_i (rx_byte, end_of_frame)
// out      output     out_valid_o/out_ready_i out_item_o (frame_ok, command, payload_length)
// cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while the input side does not stall; a result is offered once its last byte is taken.
// An input register feeds the frame state and CRC update, which feeds the result register.
// The input side stalls only when a last byte waits on a result register still held.
// Reset clears the frame state and loads the default header and footer bytes.
`default_nettype none

module crc8_serial_frame_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire crc8sfc_pkg::in_item_t     in_item_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      crc8sfc_pkg::out_item_t    out_item_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [0:0]                cfg_index_i,
  input  wire logic [7:0]                cfg_data_i
);
  import crc8sfc_pkg::*;

  logic             s1_valid_q;
  in_item_t         s1_item_q;
  logic             out_valid_q;
  out_item_t        out_item_q;
  logic [ByteW-1:0] header_q;
  logic [ByteW-1:0] footer_q;

  logic      out_free;
  logic      s1_adv;
  out_item_t result;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_item_q.end_of_frame || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  crc8sfc_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .item_i   (s1_item_q),
    .header_i (header_q),
    .footer_i (footer_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
      footer_q <= FooterReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgHeader: header_q <= cfg_data_i;
        CfgFooter: footer_q <= cfg_data_i;
        default:   header_q <= header_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && s1_item_q.end_of_frame;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_adv && s1_item_q.end_of_frame) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ----- design/crc8sfc_checker.sv -----
`default_nettype none

module crc8sfc_checker (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o,
  input wire crc8sfc_pkg::in_item_t   in_item_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire crc8sfc_pkg::out_item_t  out_item_o
);
  import crc8sfc_pkg::*;

  // A result held back by the consumer stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result item changed while stalled");

  // A fresh result is first seen only after a frame's last byte has passed the input register and the result register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_item_i.end_of_frame, 2))
    else $error("result item without a preceding last byte");

  // With room on the output side the input side never stalls.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled with the output free");

endmodule

bind crc8_serial_frame_checker crc8sfc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
